// ===== hdl/pap_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// shared types and constants for the polygon area and perimeter core
// no dependencies

package pap_pkg;

  // field widths
  localparam int COORD_W = 16;
  localparam int AREA_W  = 42;
  localparam int PERIM_W = 35;
  localparam int CROSS_W = 43;

  // polygon size limit: vertices past this count are dropped
  localparam int MAX_VERTICES = 1024;
  localparam int TAKEN_W      = $clog2(MAX_VERTICES + 1);

  // serial datapath widths
  localparam int MAG_W        = COORD_W;          // magnitude of a coord or a difference
  localparam int PROD_W       = 2 * MAG_W;        // one unsigned product
  localparam int EDGE_CROSS_W = PROD_W + 2;       // signed cross term of one edge
  localparam int D2_W         = PROD_W + 2;       // squared edge length
  localparam int FRAC_W       = 8;                // fraction bits of the perimeter
  localparam int RAD_W        = D2_W + 2 * FRAC_W; // radicand, even width
  localparam int ROOT_W       = RAD_W / 2;
  localparam int REM_W        = ROOT_W + 2;
  localparam int CNT_W        = $clog2(ROOT_W);

  // cross sum saturation bound, +/-(2^42 - 1)
  localparam logic signed [CROSS_W-1:0] CROSS_MAX = {1'b0, {(CROSS_W-1){1'b1}}};
  localparam logic [PERIM_W-1:0]        LENGTH_MAX = {PERIM_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MIX,
    ST_ROOT,
    ST_ACC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic                      last_vertex;
  } in_t;

  typedef struct packed {
    logic [AREA_W-1:0]  area_twice;
    logic [PERIM_W-1:0] perimeter_q8;
  } out_t;

endpackage

`default_nettype wire

// ===== hdl/polygon_area_perimeter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// shoelace area and perimeter of a closed polygon, bit-serial datapath
// depends on pap_pkg

// Vertices arrive one per transfer with a flag on the final one; one result
// follows each final vertex, holding twice the absolute area (zero below three
// vertices) and the perimeter with 8 fraction bits, each edge length being
// floor(256 * sqrt(dx^2 + dy^2)). Each edge runs through a shared serial unit:
// four 16x16 shift-add multipliers at one bit per cycle, a combine step, a
// restoring square root at one result bit per cycle and an accumulate step.
// The first vertex of a polygon needs no edge; the input is not ready again
// after a further vertex until its edge is through the unit, and after a final
// vertex that also closes the polygon until the closing edge and the result
// load are through too. Vertices beyond MAX_VERTICES are dropped; a dropped
// final vertex still closes the polygon. The result sits in an output
// register, so it may wait while the next polygon starts.

module polygon_area_perimeter_core
  import pap_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  // magnitude of a coordinate
  function automatic logic [MAG_W-1:0] coord_mag(input logic signed [COORD_W-1:0] v);
    logic signed [COORD_W-1:0] n;
    n = -v;
    return v[COORD_W-1] ? MAG_W'(n) : MAG_W'(v);
  endfunction

  // magnitude of a coordinate difference
  function automatic logic [MAG_W-1:0] diff_mag(input logic signed [COORD_W:0] v);
    logic signed [COORD_W:0] n;
    n = -v;
    return v[COORD_W] ? n[MAG_W-1:0] : v[MAG_W-1:0];
  endfunction

  // control state
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic               close_r;
  logic               emit_r;
  logic               out_valid_r;

  // polygon state
  logic signed [COORD_W-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic signed [CROSS_W-1:0] cross_sum_r;
  logic [PERIM_W-1:0]        length_sum_r;
  logic [1:0]                seen_r;
  logic [TAKEN_W-1:0]        taken_r;

  // serial datapath
  logic [MAG_W-1:0]               mc_r   [4];
  logic [PROD_W-1:0]              prod_r [4];
  logic                           sgn1_r, sgn2_r;
  logic signed [EDGE_CROSS_W-1:0] edge_cross_r;
  logic [RAD_W-1:0]               rad_r;
  logic [REM_W-1:0]               rem_r;
  logic [ROOT_W-1:0]              root_r;
  out_t                           out_data_r;

  // decode of the incoming vertex
  logic dropped, need_edge, accept;
  assign dropped   = (taken_r == TAKEN_W'(MAX_VERTICES));
  assign need_edge = !dropped && (taken_r != '0);
  assign accept    = in_valid && in_ready;

  // fsm outputs
  logic                      load_go, emit_go;
  logic signed [COORD_W-1:0] ld_ax, ld_ay, ld_bx, ld_by;

  always_comb begin
    in_ready = 1'b0;
    load_go  = 1'b0;
    emit_go  = 1'b0;
    ld_ax    = prev_x_r;
    ld_ay    = prev_y_r;
    ld_bx    = first_x_r;
    ld_by    = first_y_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (need_edge) begin
            // edge from the previous vertex to this one
            load_go = 1'b1;
            ld_bx   = in_data.x_coord;
            ld_by   = in_data.y_coord;
          end else if (in_data.last_vertex) begin
            // closing edge only; a lone vertex closes onto itself
            load_go = 1'b1;
            if (!dropped) begin
              ld_ax = in_data.x_coord;
              ld_ay = in_data.y_coord;
              ld_bx = in_data.x_coord;
              ld_by = in_data.y_coord;
            end
          end
        end
      end
      ST_ACC: begin
        // closing edge from the last vertex back to the first
        if (close_r) begin
          load_go = 1'b1;
        end
      end
      ST_EMIT: begin
        emit_go = !out_valid_r || out_ready;
      end
      default: begin
      end
    endcase
  end

  // fsm next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && (need_edge || in_data.last_vertex)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (cnt_r == CNT_W'(MAG_W - 1)) begin
          state_nxt = ST_MIX;
        end
      end
      ST_MIX: begin
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        if (cnt_r == CNT_W'(ROOT_W - 1)) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        if (close_r) begin
          state_nxt = ST_MUL;
        end else if (emit_r) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_MUL || state_r == ST_ROOT) && state_nxt == state_r) begin
        cnt_r <= cnt_r + 1'b1;
      end else begin
        cnt_r <= '0;
      end
    end
  end

  // operand magnitudes for a new edge
  logic signed [COORD_W:0] ld_dx, ld_dy;
  assign ld_dx = {ld_bx[COORD_W-1], ld_bx} - {ld_ax[COORD_W-1], ld_ax};
  assign ld_dy = {ld_by[COORD_W-1], ld_by} - {ld_ay[COORD_W-1], ld_ay};

  // combine products into the edge cross term and squared length
  logic signed [EDGE_CROSS_W-1:0] term1, term2;
  logic [D2_W-1:0]                d2;
  always_comb begin
    term1 = $signed({2'b00, prod_r[0]});
    term2 = $signed({2'b00, prod_r[1]});
    if (sgn1_r) begin
      term1 = -term1;
    end
    if (sgn2_r) begin
      term2 = -term2;
    end
    d2 = {2'b00, prod_r[2]} + {2'b00, prod_r[3]};
  end

  // one restoring square root step
  logic [REM_W-1:0] rem_sh, trial;
  logic             root_bit;
  assign rem_sh   = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial    = {root_r, 2'b01};
  assign root_bit = (rem_sh >= trial);

  // shift-add multipliers, combine step and root iterations
  always_ff @(posedge clk) begin
    if (load_go) begin
      mc_r[0]   <= coord_mag(ld_ax);
      prod_r[0] <= {{MAG_W{1'b0}}, coord_mag(ld_by)};
      mc_r[1]   <= coord_mag(ld_bx);
      prod_r[1] <= {{MAG_W{1'b0}}, coord_mag(ld_ay)};
      mc_r[2]   <= diff_mag(ld_dx);
      prod_r[2] <= {{MAG_W{1'b0}}, diff_mag(ld_dx)};
      mc_r[3]   <= diff_mag(ld_dy);
      prod_r[3] <= {{MAG_W{1'b0}}, diff_mag(ld_dy)};
      sgn1_r    <= ld_ax[COORD_W-1] ^ ld_by[COORD_W-1];
      sgn2_r    <= ld_bx[COORD_W-1] ^ ld_ay[COORD_W-1];
    end else if (state_r == ST_MUL) begin
      for (int i = 0; i < 4; i++) begin
        prod_r[i] <= {({1'b0, prod_r[i][PROD_W-1:MAG_W]}
                       + (prod_r[i][0] ? {1'b0, mc_r[i]} : {(MAG_W+1){1'b0}})),
                      prod_r[i][MAG_W-1:1]};
      end
    end
    if (state_r == ST_MIX) begin
      edge_cross_r <= term1 - term2;
      rad_r        <= {d2, {(2*FRAC_W){1'b0}}};
      rem_r        <= '0;
      root_r       <= '0;
    end else if (state_r == ST_ROOT) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= root_bit ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[ROOT_W-2:0], root_bit};
    end
  end

  // saturating accumulators
  logic signed [CROSS_W:0] cross_ext, cross_max_ext;
  logic signed [CROSS_W:0] cross_sat;
  logic [PERIM_W:0]        length_ext;
  logic [PERIM_W-1:0]      length_sat;
  always_comb begin
    cross_max_ext = $signed({CROSS_MAX[CROSS_W-1], CROSS_MAX});
    cross_ext = $signed({cross_sum_r[CROSS_W-1], cross_sum_r})
              + $signed({{(CROSS_W+1-EDGE_CROSS_W){edge_cross_r[EDGE_CROSS_W-1]}},
                         edge_cross_r});
    if (cross_ext > cross_max_ext) begin
      cross_sat = cross_max_ext;
    end else if (cross_ext < -cross_max_ext) begin
      cross_sat = -cross_max_ext;
    end else begin
      cross_sat = cross_ext;
    end
    length_ext = {1'b0, length_sum_r} + {{(PERIM_W+1-ROOT_W){1'b0}}, root_r};
    length_sat = length_ext[PERIM_W] ? LENGTH_MAX : length_ext[PERIM_W-1:0];
  end

  // absolute area for the result
  logic signed [CROSS_W-1:0] cross_neg;
  logic [AREA_W-1:0]         area_abs;
  assign cross_neg = -cross_sum_r;
  assign area_abs  = cross_sum_r[CROSS_W-1] ? cross_neg[AREA_W-1:0]
                                            : cross_sum_r[AREA_W-1:0];

  // polygon bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n || emit_go) begin
      first_x_r    <= '0;
      first_y_r    <= '0;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      cross_sum_r  <= '0;
      length_sum_r <= '0;
      seen_r       <= '0;
      taken_r      <= '0;
      close_r      <= 1'b0;
      emit_r       <= 1'b0;
    end else begin
      if (accept) begin
        if (!dropped) begin
          if (taken_r == '0) begin
            first_x_r <= in_data.x_coord;
            first_y_r <= in_data.y_coord;
          end
          prev_x_r <= in_data.x_coord;
          prev_y_r <= in_data.y_coord;
          taken_r  <= taken_r + 1'b1;
          if (seen_r != 2'd3) begin
            seen_r <= seen_r + 1'b1;
          end
        end
        close_r <= need_edge && in_data.last_vertex;
        emit_r  <= in_data.last_vertex;
      end
      if (state_r == ST_ACC) begin
        cross_sum_r  <= cross_sat[CROSS_W-1:0];
        length_sum_r <= length_sat;
        close_r      <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_data_r.area_twice   <= (seen_r == 2'd3) ? area_abs : '0;
      out_data_r.perimeter_q8 <= length_sum_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a waiting result is never overwritten
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_valid_r && !out_ready) |=> (state_r == ST_EMIT && out_valid_r))
    else $error("result loaded while the output register was occupied");

  // emitting a result clears the polygon
  assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |=> (taken_r == '0 && seen_r == '0 && cross_sum_r == '0 && length_sum_r == '0))
    else $error("polygon state not cleared after a result transfer");

  // cross sum stays within its saturation bounds
  assert property (@(posedge clk) disable iff (!rst_n)
    (cross_sum_r <= CROSS_MAX) && (cross_sum_r >= -CROSS_MAX))
    else $error("cross sum outside its saturation bounds");

  // vertex count and area qualifier track each other
  assert property (@(posedge clk) disable iff (!rst_n)
    (int'(taken_r) >= 3) |-> (seen_r == 2'd3))
    else $error("vertex count and seen count disagree");

endmodule

`default_nettype wire

// ===== sim/pap_checker.sv =====
`timescale 1ns / 1ps
// checker for the polygon area and perimeter core: predicts each result from the
// vertex transfers it sees and compares it with the result transfers; uses pap_pkg

module pap_checker
  import pap_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_ready,
  input  wire in_t  in_data,
  input  wire logic out_valid,
  input  wire logic out_ready,
  input  wire out_t out_data,
  output int        outstanding,
  output int        mismatches
);

  localparam longint      WEDGE_SAT = longint'(CROSS_MAX);
  localparam logic [63:0] LEN_SAT   = 64'(LENGTH_MAX);
  localparam int          SHOWN_MAX = 10;

  // running state of the polygon being taken
  logic signed [COORD_W-1:0] first_x, first_y, prev_x, prev_y;
  longint                    wedge_sum;
  logic [63:0]               len_sum;
  int                        corners_seen;
  int                        vertices_taken;

  out_t polygon_results_q[$];
  int   errs = 0;

  // floor of the square root, one result bit per pass
  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] root, trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  function automatic void clear_polygon();
    first_x        = '0;
    first_y        = '0;
    prev_x         = '0;
    prev_y         = '0;
    wedge_sum      = 0;
    len_sum        = '0;
    corners_seen   = 0;
    vertices_taken = 0;
  endfunction

  // one edge a->b: shoelace term plus 256 * length, both saturating
  function automatic void add_side(input logic signed [COORD_W-1:0] ax, ay, bx, by);
    longint      wedge, dx, dy;
    logic [63:0] dist_sq;
    wedge   = longint'(ax) * longint'(by) - longint'(bx) * longint'(ay);
    dx      = longint'(bx) - longint'(ax);
    dy      = longint'(by) - longint'(ay);
    dist_sq = dx * dx + dy * dy;
    wedge_sum += wedge;
    if (wedge_sum > WEDGE_SAT) wedge_sum = WEDGE_SAT;
    else if (wedge_sum < -WEDGE_SAT) wedge_sum = -WEDGE_SAT;
    len_sum += floor_sqrt(dist_sq << (2 * FRAC_W));
    if (len_sum > LEN_SAT) len_sum = LEN_SAT;
  endfunction

  // vertices past the size limit are dropped, but a dropped final one still closes
  function automatic void take_vertex(input in_t v);
    out_t   res;
    longint mag;
    if (vertices_taken < MAX_VERTICES) begin
      if (vertices_taken == 0) begin
        first_x = v.x_coord;
        first_y = v.y_coord;
      end else begin
        add_side(prev_x, prev_y, v.x_coord, v.y_coord);
      end
      prev_x = v.x_coord;
      prev_y = v.y_coord;
      vertices_taken++;
      if (corners_seen < 3) corners_seen++;
    end
    if (v.last_vertex) begin
      if (vertices_taken != 0) add_side(prev_x, prev_y, first_x, first_y);
      mag = (wedge_sum < 0) ? -wedge_sum : wedge_sum;
      res.area_twice   = (corners_seen >= 3) ? AREA_W'(mag) : '0;
      res.perimeter_q8 = PERIM_W'(len_sum);
      polygon_results_q.push_back(res);
      clear_polygon();
    end
  endfunction

  function automatic void flag(input string msg);
    errs++;
    if (errs <= SHOWN_MAX) $display("%t: %s", $realtime, msg);
  endfunction

  // watch both channels; compare a result transfer before taking a vertex
  always @(posedge clk) begin
    out_t exp_res;
    if (!rst_n) begin
      clear_polygon();
      polygon_results_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (polygon_results_q.size() == 0) begin
          flag($sformatf("unexpected result: area_twice %0d perimeter_q8 %0d",
                         out_data.area_twice, out_data.perimeter_q8));
        end else begin
          exp_res = polygon_results_q.pop_front();
          if (out_data.area_twice !== exp_res.area_twice)
            flag($sformatf("area_twice mismatch: expected %0d, got %0d",
                           exp_res.area_twice, out_data.area_twice));
          if (out_data.perimeter_q8 !== exp_res.perimeter_q8)
            flag($sformatf("perimeter_q8 mismatch: expected %0d, got %0d",
                           exp_res.perimeter_q8, out_data.perimeter_q8));
        end
      end
      if (in_valid && in_ready) take_vertex(in_data);
    end
    outstanding <= polygon_results_q.size();
    mismatches  <= errs;
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// top of the polygon area and perimeter testbench: clock, reset, vertex and
// result traffic, verdict; uses pap_pkg, polygon_area_perimeter_core, pap_checker

module tb
  import pap_pkg::*;
();

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_ITEMS = 500;
  localparam int LONG_POLYGON = MAX_VERTICES + 4;
  localparam int LONG_HOLD    = 3000;
  localparam int HOLD_AT      = 15;
  localparam int DRAIN_CYCLES = 200;

  localparam logic signed [COORD_W-1:0] C_MIN = 16'sh8000;
  localparam logic signed [COORD_W-1:0] C_MAX = 16'sh7FFF;

  typedef enum int {
    COORD_FULL,
    COORD_NEAR,
    COORD_EDGES
  } coord_mix_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready;
  in_t  in_data;
  logic out_valid, out_ready;
  out_t out_data;

  int outstanding, mismatches;
  int cycles = 0;
  bit quiet_send = 1'b0;
  bit quiet_recv = 1'b0;

  polygon_area_perimeter_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  pap_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(40, 120);
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_coord(input coord_mix_t mix);
    int v;
    case (mix)
      COORD_NEAR: begin
        v = int'($urandom_range(0, 200)) - 100;
        return v[COORD_W-1:0];
      end
      COORD_EDGES: begin
        case ($urandom_range(0, 5))
          0: return C_MIN;
          1: return C_MAX;
          2: return '0;
          3: return '1;
          4: return 16'sd1;
          default: return COORD_W'($urandom());
        endcase
      end
      default: return COORD_W'($urandom());
    endcase
  endfunction

  // offer one vertex, after an optional gap, and hold it until the transfer
  task automatic send_vertex(input logic signed [COORD_W-1:0] x, y, input logic last);
    int gap;
    gap = quiet_send ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= in_t'{x_coord: x, y_coord: y, last_vertex: last};
    do @(posedge clk); while (!in_ready);
  endtask

  // stop offering until every predicted result has been transferred
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // result side: random ready, short and long holds, one very long hold
  initial begin : receiver
    int hold;
    int results_seen;
    bit long_hold_done;
    hold           = 0;
    results_seen   = 0;
    long_hold_done = 1'b0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) results_seen++;
      if (!long_hold_done && results_seen == HOLD_AT) begin
        long_hold_done = 1'b1;
        hold           = LONG_HOLD;
      end else if (hold == 0 && !quiet_recv && $urandom_range(0, 199) == 0) begin
        hold = $urandom_range(20, 120);
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet_recv ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
    end
  end

  initial begin : stimulus
    int sent, polygons, corner_count, r;
    coord_mix_t mix;
    logic signed [COORD_W-1:0] corner_x [4];
    logic signed [COORD_W-1:0] corner_y [4];
    corner_x = '{C_MIN, C_MAX, C_MAX, C_MIN};
    corner_y = '{C_MIN, C_MIN, C_MAX, C_MAX};
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single vertex: closing edge of length zero, both fields zero
    send_vertex(C_MIN, C_MAX, 1'b1);
    // two vertices: no area, edge counted twice
    send_vertex(C_MIN, C_MIN, 1'b0);
    send_vertex(C_MAX, C_MAX, 1'b1);
    // largest triangle
    send_vertex(C_MIN, C_MIN, 1'b0);
    send_vertex(C_MAX, C_MIN, 1'b0);
    send_vertex(C_MIN, C_MAX, 1'b1);
    // clockwise square, negative shoelace sum
    send_vertex(16'sd0, 16'sd0, 1'b0);
    send_vertex(16'sd0, 16'sd100, 1'b0);
    send_vertex(16'sd100, 16'sd100, 1'b0);
    send_vertex(16'sd100, 16'sd0, 1'b1);
    // collinear points
    send_vertex(16'sd1, 16'sd1, 1'b0);
    send_vertex(16'sd2, 16'sd2, 1'b0);
    send_vertex(16'sd3, 16'sd3, 1'b1);
    // one point repeated
    send_vertex(16'sd5, -16'sd5, 1'b0);
    send_vertex(16'sd5, -16'sd5, 1'b0);
    send_vertex(16'sd5, -16'sd5, 1'b1);
    // self-crossing pentagon on the extremes
    send_vertex(C_MAX, 16'sd0, 1'b0);
    send_vertex(16'sd0, C_MAX, 1'b0);
    send_vertex(C_MIN, 16'sd0, 1'b0);
    send_vertex(16'sd0, C_MIN, 1'b0);
    send_vertex(C_MAX, C_MAX, 1'b1);
    wait_for_results();

    // size limit: full square wound many times, then dropped vertices,
    // the final one dropped too but still closing the polygon
    for (int k = 0; k < LONG_POLYGON; k++) begin
      if (k < MAX_VERTICES)
        send_vertex(corner_x[k % 4], corner_y[k % 4], 1'b0);
      else
        send_vertex(pick_coord(COORD_FULL), pick_coord(COORD_FULL),
                    k == LONG_POLYGON - 1);
    end
    wait_for_results();

    // random polygons, mostly small
    sent     = 0;
    polygons = 0;
    while (sent < RANDOM_ITEMS) begin
      quiet_send <= ($urandom_range(0, 3) == 0);
      quiet_recv <= ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 10) corner_count = $urandom_range(1, 2);
      else if (r < 88) corner_count = $urandom_range(3, 8);
      else corner_count = $urandom_range(9, 40);
      mix = coord_mix_t'($urandom_range(0, 2));
      for (int v = 0; v < corner_count; v++)
        send_vertex(pick_coord(mix), pick_coord(mix), v == corner_count - 1);
      sent += corner_count;
      polygons++;
      if (polygons % 25 == 0) wait_for_results();
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== polygon_area_perimeter_core.f =====
hdl/pap_pkg.sv
hdl/polygon_area_perimeter_core.sv
sim/pap_checker.sv
sim/tb.sv
